FILE: rtl/line_raster_pixel_engine_assert.svh
// Assertion macros shared by the line raster pixel engine RTL.
`ifndef LINE_RASTER_PIXEL_ENGINE_ASSERT_SVH
`define LINE_RASTER_PIXEL_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LRPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lrpe_pkg.sv
// Types, codes and frame geometry for the line raster pixel engine.
package lrpe_pkg;

  localparam int COLUMNS = 96;
  localparam int ROWS    = 68;
  localparam int BANKS   = (ROWS + 7) / 8;
  localparam int DEPTH   = COLUMNS * BANKS;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int BANK_W  = ROW_W - 3;
  localparam int ERR_W   = 10;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [COL_W-1:0] x_start;
    logic [ROW_W-1:0] y_start;
    logic [COL_W-1:0] x_end;
    logic [ROW_W-1:0] y_end;
    logic [1:0]       draw_op;
  } lrpe_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [BANK_W-1:0] bank;
    logic [7:0]        data_byte;
    logic              last;
  } lrpe_upd_t;

endpackage

FILE: rtl/line_raster_pixel_engine.sv
// Line raster pixel engine: monochrome frame store plus Bresenham line stepper.
// Channels:
//   Command channel (cmd_valid / cmd_stall / cmd): one item per command. A pixel
//   item sets, clears or inverts one frame pixel; a line-start item loads both
//   endpoints and the mode and returns nothing; each step item plots the next
//   pixel of the active line. A step with no line active and an unused kind
//   return nothing.
//   Update channel (upd_valid / upd_stall / upd): one item per plotted pixel,
//   carrying column, bank and new byte, with last set on a single pixel and
//   on the final pixel of a line.
// Timing:
//   A plotting item: the accept edge issues the frame read into rd_data and
//   enters ST_MODIFY; there, once the output register is free, the modified
//   byte is written back and loaded into the output register. Line starts and
//   ignored items stay in ST_IDLE. The registered frame read port sets this.
// Reset: rst (synchronous) drops the line and the output, then a clearing
//   pass writes zero to all 864 frame bytes, one per cycle, with cmd_stall
//   high throughout the pass.
// Backpressure: a finished byte waits in the output register while the next
//   item is taken; the following write-back holds until upd_stall drops.
`include "line_raster_pixel_engine_assert.svh"

module line_raster_pixel_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  lrpe_pkg::lrpe_cmd_t   cmd,
  output logic                  upd_valid,
  input  logic                  upd_stall,
  output lrpe_pkg::lrpe_upd_t   upd
);
  import lrpe_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_t;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

  state_t state;
  logic [ADDR_W-1:0] clr_addr;

  // Frame store and its registered read port
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  // Pending read-modify-write
  logic [ADDR_W-1:0] op_addr;
  logic [COL_W-1:0]  op_col;
  logic [BANK_W-1:0] op_bank;
  logic [2:0]        op_bit;
  logic [1:0]        op_mode;
  logic              op_last;

  // Line state
  logic                    line_active;
  logic [COL_W-1:0]        cur_x;
  logic [ROW_W-1:0]        cur_y;
  logic [COL_W-1:0]        steps_left;
  logic signed [ERR_W-1:0] error_term;
  logic [7:0]              minor_twice;
  logic signed [ERR_W-1:0] diag_delta;
  logic                    x_major;
  logic                    x_negative;
  logic                    y_negative;
  logic [1:0]              line_mode;

  logic              cmd_accept;
  logic              do_plot;
  logic              out_free;
  logic              upd_load;
  logic [COL_W-1:0]  px_x, ex_x, plot_x;
  logic [ROW_W-1:0]  px_y, ex_y, plot_y;
  logic [BANK_W-1:0] plot_bank;
  logic [ADDR_W-1:0] plot_addr;
  logic [COL_W-1:0]  dx, dy, maj, mnr;
  logic              x_major_next;
  logic [7:0]        minor_twice_next;
  logic signed [ERR_W-1:0] error_next, diag_next, error_step;
  logic              diag;
  logic [7:0]        bit_mask, new_byte;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign out_free   = !upd_valid || !upd_stall;
  assign upd_load   = (state == ST_MODIFY) && out_free;

  // Saturate coordinates onto the frame
  assign px_x = (cmd.x_start > COL_MAX) ? COL_MAX : cmd.x_start;
  assign px_y = (cmd.y_start > ROW_MAX) ? ROW_MAX : cmd.y_start;
  assign ex_x = (cmd.x_end > COL_MAX) ? COL_MAX : cmd.x_end;
  assign ex_y = (cmd.y_end > ROW_MAX) ? ROW_MAX : cmd.y_end;

  assign plot_x    = (cmd.kind == KIND_STEP) ? cur_x : px_x;
  assign plot_y    = (cmd.kind == KIND_STEP) ? cur_y : px_y;
  assign plot_bank = plot_y[ROW_W-1:3];
  assign plot_addr = ADDR_W'(plot_bank) * ADDR_W'(COLUMNS) + ADDR_W'(plot_x);

  assign do_plot = cmd_accept &&
                   ((cmd.kind == KIND_PIXEL) || ((cmd.kind == KIND_STEP) && line_active));

  // Line setup: deltas, major axis and initial error terms
  assign dx               = (ex_x >= px_x) ? (ex_x - px_x) : (px_x - ex_x);
  assign dy               = (ex_y >= px_y) ? (ex_y - px_y) : (px_y - ex_y);
  assign x_major_next     = (dx >= dy);
  assign maj              = x_major_next ? dx : dy;
  assign mnr              = x_major_next ? dy : dx;
  assign minor_twice_next = {mnr, 1'b0};
  assign error_next       = $signed({2'b00, minor_twice_next}) - $signed({3'b000, maj});
  assign diag_next        = error_next - $signed({3'b000, maj});

  // Step: move diagonally while the error term is non-negative
  assign diag       = !error_term[ERR_W-1];
  assign error_step = error_term + (diag ? diag_delta : $signed({2'b00, minor_twice}));

  // Modify the fetched byte
  assign bit_mask = 8'd1 << op_bit;
  always_comb begin
    case (op_mode)
      MODE_SET:    new_byte = rd_data | bit_mask;
      MODE_CLEAR:  new_byte = rd_data & ~bit_mask;
      MODE_INVERT: new_byte = rd_data ^ bit_mask;
      default:     new_byte = rd_data;
    endcase
  end

  assign mem_we    = (state == ST_CLEAR) || ((state == ST_MODIFY) && out_free);
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : op_addr;
  assign mem_wdata = (state == ST_CLEAR) ? 8'd0 : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (do_plot) begin
      rd_data <= mem[plot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      upd_valid   <= 1'b0;
      line_active <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      steps_left  <= '0;
      error_term  <= '0;
      minor_twice <= '0;
      diag_delta  <= '0;
      x_major     <= 1'b0;
      x_negative  <= 1'b0;
      y_negative  <= 1'b0;
      line_mode   <= '0;
    end else begin
      // Raise valid on a new byte, drop it once the sink takes the item
      if (upd_load) begin
        upd_valid <= 1'b1;
      end else if (!upd_stall) begin
        upd_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (do_plot) begin
            op_addr <= plot_addr;
            op_col  <= plot_x;
            op_bank <= plot_bank;
            op_bit  <= plot_y[2:0];
            op_mode <= (cmd.kind == KIND_STEP) ? line_mode : cmd.draw_op;
            op_last <= (cmd.kind == KIND_PIXEL) || (steps_left == '0);
            state   <= ST_MODIFY;
          end
          if (cmd_accept && (cmd.kind == KIND_LINE)) begin
            // Abandon any active line and load the new one
            line_active <= 1'b1;
            cur_x       <= px_x;
            cur_y       <= px_y;
            steps_left  <= maj;
            error_term  <= error_next;
            minor_twice <= minor_twice_next;
            diag_delta  <= diag_next;
            x_major     <= x_major_next;
            x_negative  <= (px_x > ex_x);
            y_negative  <= (px_y > ex_y);
            line_mode   <= cmd.draw_op;
          end
          if (cmd_accept && (cmd.kind == KIND_STEP) && line_active) begin
            if (steps_left == '0) begin
              line_active <= 1'b0;
            end else begin
              error_term <= error_step;
              if (x_major || diag) begin
                cur_x <= x_negative ? (cur_x - 1'b1) : (cur_x + 1'b1);
              end
              if (!x_major || diag) begin
                cur_y <= y_negative ? (cur_y - 1'b1) : (cur_y + 1'b1);
              end
              steps_left <= steps_left - 1'b1;
            end
          end
        end
        ST_MODIFY: begin
          // Hold the write-back until the output register can take the byte
          if (out_free) begin
            upd   <= '{column: op_col, bank: op_bank, data_byte: new_byte,
                       last: op_last};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  `LRPE_ASSERT_NEXT(a_plot_reaches_modify, do_plot, state == ST_MODIFY, "plot item lost")
  `LRPE_ASSERT_NEXT(a_final_step_ends_line,
                    cmd_accept && cmd.kind == KIND_STEP && line_active && steps_left == '0,
                    !line_active, "line still active after its final pixel")
  `LRPE_ASSERT_IMP(a_no_result_in_clear, state == ST_CLEAR, !upd_valid,
                   "result shown during clearing pass")

endmodule
